@@ design/itoa_pkg.sv @@
// ----------------------------------------------------------------------------
// itoa_pkg
// shared types, mode codes and character constants for the integer to ascii
// formatter
// ----------------------------------------------------------------------------
`default_nettype none

package itoa_pkg;

    typedef logic [1:0] mode_t;

    localparam mode_t MODE_DEC  = 2'd0;
    localparam mode_t MODE_HEX  = 2'd1;
    localparam mode_t MODE_CHR  = 2'd2;
    localparam mode_t MODE_NONE = 2'd3;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CHAR_LOW_A = 8'h61;  // 'a'
    localparam logic [7:0] CHAR_MINUS = 8'h2d;  // '-'
    localparam logic [7:0] CHAR_X     = 8'h78;  // 'x'

    localparam logic [3:0] DEC_RADIX = 4'd10;

    // classification handed from front to back
    typedef struct packed {
        mode_t mode;
        logic  neg;
    } fmt_ctl_t;

    // one decimal or hex digit to its lower-case ascii code
    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] c;
        if (d < DEC_RADIX) begin
            c = CHAR_ZERO + {4'd0, d};
        end else begin
            c = CHAR_LOW_A + {4'd0, d - DEC_RADIX};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ design/itoa_front.sv @@
// ----------------------------------------------------------------------------
// itoa_front
// input side: takes beats, masks the word, forms sign and magnitude
// ----------------------------------------------------------------------------
`default_nettype none

module itoa_front
    import itoa_pkg::*;
#(
    parameter int WORD_BITS = 32
) (
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [31:0]          s_tdata,
    input  wire logic [1:0]           s_tuser,
    input  wire logic                 q_full,
    output logic                      push,
    output fmt_ctl_t                  push_ctl,
    output logic [WORD_BITS-1:0]      push_mag
);

    logic [WORD_BITS-1:0] word;
    logic                 accept;

    generate
        if (WORD_BITS <= 32) begin : g_narrow
            assign word = s_tdata[WORD_BITS-1:0];
        end else begin : g_wide
            assign word = {{(WORD_BITS-32){1'b0}}, s_tdata};
        end
    endgenerate

    assign s_tready = !q_full;
    assign accept   = s_tvalid && !q_full;

    always_comb begin
        push_ctl.mode = mode_t'(s_tuser);
        push_ctl.neg  = (mode_t'(s_tuser) == MODE_DEC) && word[WORD_BITS-1];
        // unused mode is taken and dropped
        push          = accept && (mode_t'(s_tuser) != MODE_NONE);
        if (push_ctl.neg) begin
            push_mag = ~word + {{(WORD_BITS-1){1'b0}}, 1'b1};
        end else begin
            push_mag = word;
        end
    end

endmodule

`default_nettype wire

@@ design/itoa_queue.sv @@
// ----------------------------------------------------------------------------
// itoa_queue
// two-entry queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module itoa_queue
    import itoa_pkg::*;
#(
    parameter int WORD_BITS = 32
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push,
    input  wire fmt_ctl_t             push_ctl,
    input  wire logic [WORD_BITS-1:0] push_mag,
    output logic                      full,
    input  wire logic                 pop,
    output logic                      q_valid,
    output fmt_ctl_t                  q_ctl,
    output logic [WORD_BITS-1:0]      q_mag
);

    localparam int DEPTH = 2;

    fmt_ctl_t             ctl_mem [DEPTH];
    logic [WORD_BITS-1:0] mag_mem [DEPTH];
    logic                 wr_ptr_reg, wr_ptr_next;
    logic                 rd_ptr_reg, rd_ptr_next;
    logic [1:0]           count_reg, count_next;

    assign full    = (count_reg == 2'(DEPTH));
    assign q_valid = (count_reg != 2'd0);
    assign q_ctl   = ctl_mem[rd_ptr_reg];
    assign q_mag   = mag_mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            ctl_mem[wr_ptr_reg] <= push_ctl;
            mag_mem[wr_ptr_reg] <= push_mag;
        end
    end

endmodule

`default_nettype wire

@@ design/itoa_back.sv @@
// ----------------------------------------------------------------------------
// itoa_back
// output side: binary to bcd by shift-add-3 for decimal, leading zero skip, character out
// ----------------------------------------------------------------------------
`default_nettype none

module itoa_back
    import itoa_pkg::*;
#(
    parameter int WORD_BITS = 32
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 q_valid,
    input  wire fmt_ctl_t             q_ctl,
    input  wire logic [WORD_BITS-1:0] q_mag,
    output logic                      pop,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [7:0]                m_tdata,
    output logic                      m_tlast
);

    localparam int NDEC  = (WORD_BITS * 30103) / 100000 + 1;
    localparam int NHEX  = (WORD_BITS + 3) / 4;
    localparam int NDIG  = (NDEC > NHEX) ? NDEC : NHEX;
    localparam int BCD_W = NDIG * 4;
    localparam int IDX_W = $clog2(NDIG);
    localparam int CNT_W = $clog2(WORD_BITS + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CONV = 3'd1;
    localparam logic [2:0] ST_SKIP = 3'd2;
    localparam logic [2:0] ST_PFX  = 3'd3;
    localparam logic [2:0] ST_DIG  = 3'd4;
    localparam logic [2:0] ST_CHR  = 3'd5;

    logic [2:0]           state_reg, state_next;
    fmt_ctl_t             ctl_reg, ctl_next;
    logic [BCD_W-1:0]     bcd_reg, bcd_next;
    logic [WORD_BITS-1:0] sh_reg, sh_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [1:0]           pfx_reg, pfx_next;
    logic                 ov_reg, ov_next;
    logic [7:0]           od_reg, od_next;
    logic                 ol_reg, ol_next;

    logic [BCD_W-1:0]     adj;
    logic [3:0]           cur_dig;
    logic                 out_free;

    assign m_tvalid = ov_reg;
    assign m_tdata  = od_reg;
    assign m_tlast  = ol_reg;
    assign out_free = !ov_reg || m_tready;
    assign cur_dig  = bcd_reg[{idx_reg, 2'b00} +: 4];

    // add 3 to every bcd digit of five or more before the shift
    always_comb begin
        for (int i = 0; i < NDIG; i++) begin
            if (bcd_reg[4*i +: 4] >= 4'd5) begin
                adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end else begin
                adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        ctl_next   = ctl_reg;
        bcd_next   = bcd_reg;
        sh_next    = sh_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        pfx_next   = pfx_reg;
        ov_next    = ov_reg && !m_tready;
        od_next    = od_reg;
        ol_next    = ol_reg;
        pop        = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    pop      = 1'b1;
                    ctl_next = q_ctl;
                    sh_next  = q_mag;
                    case (q_ctl.mode)
                        MODE_DEC: begin
                            bcd_next   = '0;
                            cnt_next   = CNT_W'(WORD_BITS);
                            state_next = ST_CONV;
                        end
                        MODE_HEX: begin
                            bcd_next   = BCD_W'(q_mag);
                            idx_next   = IDX_W'(NHEX - 1);
                            state_next = ST_SKIP;
                        end
                        default: begin
                            state_next = ST_CHR;
                        end
                    endcase
                end
            end
            ST_CONV: begin
                bcd_next = {adj[BCD_W-2:0], sh_reg[WORD_BITS-1]};
                sh_next  = {sh_reg[WORD_BITS-2:0], 1'b0};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    idx_next   = IDX_W'(NDEC - 1);
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if ((idx_reg != '0) && (cur_dig == 4'd0)) begin
                    idx_next = idx_reg - IDX_W'(1);
                end else if (ctl_reg.mode == MODE_HEX) begin
                    pfx_next   = 2'd2;
                    state_next = ST_PFX;
                end else if (ctl_reg.neg) begin
                    pfx_next   = 2'd1;
                    state_next = ST_PFX;
                end else begin
                    state_next = ST_DIG;
                end
            end
            ST_PFX: begin
                if (out_free) begin
                    ov_next  = 1'b1;
                    ol_next  = 1'b0;
                    pfx_next = pfx_reg - 2'd1;
                    if (ctl_reg.mode == MODE_HEX) begin
                        od_next = (pfx_reg == 2'd2) ? CHAR_ZERO : CHAR_X;
                    end else begin
                        od_next = CHAR_MINUS;
                    end
                    if (pfx_reg == 2'd1) begin
                        state_next = ST_DIG;
                    end
                end
            end
            ST_DIG: begin
                if (out_free) begin
                    ov_next  = 1'b1;
                    od_next  = digit_char(cur_dig);
                    ol_next  = (idx_reg == '0);
                    idx_next = idx_reg - IDX_W'(1);
                    if (idx_reg == '0) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_CHR: begin
                if (out_free) begin
                    ov_next    = 1'b1;
                    od_next    = sh_reg[7:0];
                    ol_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        ctl_reg <= ctl_next;
        bcd_reg <= bcd_next;
        sh_reg  <= sh_next;
        cnt_reg <= cnt_next;
        idx_reg <= idx_next;
        pfx_reg <= pfx_next;
        od_reg  <= od_next;
        ol_reg  <= ol_next;
    end

endmodule

`default_nettype wire

@@ design/integer_to_ascii_formatter_top.sv @@
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_top
// formats one word per input beat as ascii text, one character per output beat
// ----------------------------------------------------------------------------
// usage
//   input stream: s_tdata carries the word, s_tuser the mode (signed decimal,
//   hex with 0x prefix, single character; the fourth code is taken and
//   dropped without output)
//   output stream: m_tdata carries one character per beat, m_tlast marks the
//   final character of each word
//   the front classifies the word (sign, magnitude) and drops it into a
//   two-entry queue, so up to two words are taken while the back is busy
//   the back runs one word at a time:
//     decimal: a load, the shift-add-3 loop over the WORD_BITS bits of the
//       magnitude, the skip of leading zeros, then a sign beat if negative
//       and one beat per digit
//     hex: skip of leading zeros, then the prefix and digit beats
//     character: a single beat
//   reset (aresetn low, synchronous) empties the queue and the output register
//   a stalled receiver holds the output register; the back waits, the queue
//   fills and then s_tready drops
// ----------------------------------------------------------------------------
`default_nettype none

module integer_to_ascii_formatter_top
    import itoa_pkg::*;
#(
    parameter int WORD_BITS = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] value
    input  wire logic [1:0]  s_tuser,   // [1:0] req_type
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] char_code
    output logic             m_tlast
);

    // front to queue
    logic                 push;
    fmt_ctl_t             push_ctl;
    logic [WORD_BITS-1:0] push_mag;
    logic                 q_full;

    // queue to back
    logic                 pop;
    logic                 q_valid;
    fmt_ctl_t             q_ctl;
    logic [WORD_BITS-1:0] q_mag;

    // masks the word, forms sign and magnitude
    itoa_front #(
        .WORD_BITS(WORD_BITS)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .push     (push),
        .push_ctl (push_ctl),
        .push_mag (push_mag)
    );

    // lets the front take words while the back is still printing
    itoa_queue #(
        .WORD_BITS(WORD_BITS)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_ctl (push_ctl),
        .push_mag (push_mag),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_ctl    (q_ctl),
        .q_mag    (q_mag)
    );

    // conversion and character output, output register inside
    itoa_back #(
        .WORD_BITS(WORD_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_ctl    (q_ctl),
        .q_mag    (q_mag),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

@@ design/itoa_checker.sv @@
// ----------------------------------------------------------------------------
// itoa_checker
// port-level checks on the formatter, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module itoa_checker
    import itoa_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [7:0]  m_tdata,
    input wire logic        m_tlast
);

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output beat changed while stalled");

    // reset empties the output register
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // reset empties the queue so input is open right after
    a_reset_in: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("input not ready after reset");

    // a beat that is not last is a sign, a prefix or a digit
    a_mid_char: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |->
            ((m_tdata >= CHAR_ZERO) && (m_tdata <= CHAR_ZERO + 8'd9)) ||
            ((m_tdata >= CHAR_LOW_A) && (m_tdata <= CHAR_LOW_A + 8'd5)) ||
            (m_tdata == CHAR_X) || (m_tdata == CHAR_MINUS))
        else $error("unexpected character before end of word");

endmodule

bind integer_to_ascii_formatter_top itoa_checker u_itoa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

@@ tb/sv/tb_integer_to_ascii_formatter_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_integer_to_ascii_formatter_top
// self-checking bench for the integer to ascii formatter: a table of directed
// words (extremes, every mode, the dropped mode) followed by randomly shaped
// words; each accepted word is turned into its expected character stream from
// its row's text or by a local formatter, and every output beat is checked in
// order against it, with random idling on both the input and the output stream
// ----------------------------------------------------------------------------

module tb_integer_to_ascii_formatter_top;
    import itoa_pkg::*;

    localparam int WORD_BITS      = 32;
    localparam int N_DIRECTED     = 22;
    localparam int N_RANDOM       = 250;
    localparam int IDLE_PERCENT   = 33;
    localparam int QUIET_LIMIT    = 5000;  // cycles with no beat on either side
    localparam int DRAIN_CYCLES   = 64;

    typedef logic [7:0] char_q_t[$];

    // one expected output beat
    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } ascii_beat_t;

    // one directed word; text is used only when typed is set
    typedef struct {
        mode_t       mode;
        logic [31:0] value;
        bit          typed;
        string       text;
    } word_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;    // [31:0] value
    logic [1:0]  s_tuser  = '0;    // [1:0] req_type
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;          // [7:0] char_code
    logic        m_tlast;

    ascii_beat_t expected_chars[$];
    int          mismatch_count = 0;
    int          quiet_cycles   = 0;
    bit          calm           = 1'b0;  // no idling on either side while set

    integer_to_ascii_formatter_top #(
        .WORD_BITS (WORD_BITS)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // appends a whole word's text to the expected stream, last on its final char
    function automatic void queue_text(input char_q_t text);
        for (int i = 0; i < text.size(); i++) begin
            expected_chars.push_back('{code: text[i], last: (i == text.size() - 1)});
        end
    endfunction

    // expected characters for one accepted word
    function automatic void format_word(input mode_t mode, input logic [31:0] value);
        char_q_t     text;
        char_q_t     digits;
        logic [31:0] mag;
        logic [3:0]  nib;
        case (mode)
            MODE_CHR: begin
                text.push_back(value[7:0]);
            end
            MODE_DEC: begin
                // magnitude taken in unsigned arithmetic, so the most negative
                // word comes out as 2147483648
                if (value[WORD_BITS-1]) begin
                    text.push_back(CHAR_MINUS);
                    mag = ~value + 32'd1;
                end else begin
                    mag = value;
                end
                do begin
                    digits.push_front(CHAR_ZERO + 8'(mag % 32'd10));
                    mag = mag / 32'd10;
                end while (mag != 32'd0);
            end
            MODE_HEX: begin
                text.push_back(CHAR_ZERO);
                text.push_back(CHAR_X);
                mag = value;
                do begin
                    nib = mag[3:0];
                    digits.push_front(nib < 4'd10 ? CHAR_ZERO + 8'(nib)
                                                  : CHAR_LOW_A + 8'(nib - 4'd10));
                    mag = mag >> 4;
                end while (mag != 32'd0);
            end
            default: begin
                // unused mode: word is swallowed, nothing comes out
            end
        endcase
        foreach (digits[i]) text.push_back(digits[i]);
        queue_text(text);
    endfunction

    // presents one word, waits for its handshake, then records what it must give
    task automatic send_word(input mode_t mode, input logic [31:0] value,
                             input bit typed, input string text);
        char_q_t typed_text;
        while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= mode;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        // beat taken at this edge
        if (typed) begin
            for (int i = 0; i < text.len(); i++) typed_text.push_back(text[i]);
            queue_text(typed_text);
        end else begin
            format_word(mode, value);
        end
    endtask

    // receiver back-pressure, one draw per cycle while calm is clear
    always @(posedge aclk) begin
        m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // output checker: each char beat against the oldest expectation
    always @(posedge aclk) begin
        ascii_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_chars.size() == 0) begin
                $display("%0t: unexpected char beat: expected none, actual code %h last %b",
                         $time, m_tdata, m_tlast);
                mismatch_count++;
            end else begin
                want = expected_chars.pop_front();
                if (m_tdata !== want.code) begin
                    $display("%0t: char_code mismatch: expected %h, actual %h",
                             $time, want.code, m_tdata);
                    mismatch_count++;
                end
                if (m_tlast !== want.last) begin
                    $display("%0t: last mismatch: expected %b, actual %b",
                             $time, want.last, m_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog: ends the run when neither stream moves for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("tb_integer_to_ascii_formatter_top: done, errors");
            $finish;
        end
    end

    // directed words: extremes of every mode, the most negative word, the
    // dropped mode and a word right behind it
    word_row_t directed_rows[N_DIRECTED] = '{
        '{MODE_DEC,  32'h0000_0000, 1'b1, "0"},
        '{MODE_DEC,  32'h0000_0001, 1'b1, "1"},
        '{MODE_DEC,  32'hffff_ffff, 1'b1, "-1"},
        '{MODE_DEC,  32'h8000_0000, 1'b1, "-2147483648"},
        '{MODE_DEC,  32'h7fff_ffff, 1'b1, "2147483647"},
        '{MODE_DEC,  32'h0000_0009, 1'b0, ""},
        '{MODE_DEC,  32'h0000_000a, 1'b0, ""},
        '{MODE_DEC,  32'h3b9a_ca00, 1'b0, ""},
        '{MODE_DEC,  32'hffff_fff6, 1'b0, ""},
        '{MODE_HEX,  32'h0000_0000, 1'b1, "0x0"},
        '{MODE_HEX,  32'hffff_ffff, 1'b1, "0xffffffff"},
        '{MODE_HEX,  32'h8000_0000, 1'b1, "0x80000000"},
        '{MODE_HEX,  32'h0000_000a, 1'b1, "0xa"},
        '{MODE_HEX,  32'h1234_abcd, 1'b0, ""},
        '{MODE_HEX,  32'h0000_0010, 1'b0, ""},
        '{MODE_CHR,  32'h0000_0041, 1'b1, "A"},
        '{MODE_CHR,  32'hffff_ff00, 1'b0, ""},
        '{MODE_CHR,  32'h0000_00ff, 1'b0, ""},
        '{MODE_CHR,  32'ha5a5_a57e, 1'b1, "~"},
        '{MODE_NONE, 32'h1234_5678, 1'b1, ""},
        '{MODE_NONE, 32'hffff_ffff, 1'b1, ""},
        '{MODE_DEC,  32'h0000_007b, 1'b1, "123"}
    };

    initial begin
        int          sent;
        mode_t       mode;
        logic [31:0] value;

        // reset held low at the start, then released
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            send_word(directed_rows[i].mode, directed_rows[i].value,
                      directed_rows[i].typed, directed_rows[i].text);
        end

        // random words; dropped-mode words are noise and do not count
        sent = 0;
        while (sent < N_RANDOM) begin
            calm = (sent >= 120 && sent < 170);
            if ($urandom_range(0, 99) < 4) begin
                mode = MODE_NONE;
            end else begin
                mode = mode_t'($urandom_range(0, 2));
                sent++;
            end
            case ($urandom_range(0, 4))
                0: value = $urandom;
                1: value = $urandom_range(0, 20);
                2: value = -$urandom_range(1, 20);
                3: value = (32'd1 << $urandom_range(0, 31)) - $urandom_range(0, 1);
                default: value = $urandom >> $urandom_range(0, 31);
            endcase
            send_word(mode, value, 1'b0, "");
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;

        // let every expected char come out, then watch for strays
        while (expected_chars.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("tb_integer_to_ascii_formatter_top: done, clean");
        end else begin
            $display("tb_integer_to_ascii_formatter_top: done, errors");
        end
        $finish;
    end

endmodule
